### rtl/core/sil_pkg.sv
// Shared types and constants of the sorted insert list.
// Used by sil_cell, sil_tap_reduce and sorted_insert_list; depends on nothing.
package sil_pkg;

    localparam int KEY_W      = 32;
    localparam int POS_W      = 6;
    localparam int OUT_CNT_W  = 7;
    // positions reach only the first 2**POS_W cells
    localparam int TAP_N      = 1 << POS_W;
    localparam int TAP_GROUP  = 8;
    localparam int TAP_GROUPS = TAP_N / TAP_GROUP;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] weight;
        logic [POS_W-1:0]        pos;
    } cell_ctrl_t;

endpackage

### rtl/core/sil_cell.sv
// One cell of the sorted chain: holds one key and weight, trades with its neighbors.
// Depends on sil_pkg.
module sil_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                             clk,
    input  sil_pkg::cell_ctrl_t              ctrl,
    input  logic [CNT_W-1:0]                 count,
    input  logic                             tap_load,
    input  logic                             left_gt,
    input  logic signed [sil_pkg::KEY_W-1:0] left_key,
    input  logic signed [sil_pkg::KEY_W-1:0] left_weight,
    input  logic signed [sil_pkg::KEY_W-1:0] right_key,
    input  logic signed [sil_pkg::KEY_W-1:0] right_weight,
    output logic signed [sil_pkg::KEY_W-1:0] key,
    output logic signed [sil_pkg::KEY_W-1:0] weight,
    output logic                             gt,
    output logic [sil_pkg::KEY_W-1:0]        tap
);
    import sil_pkg::*;

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] weight_reg, weight_next;
    logic [KEY_W-1:0]        tap_reg, tap_next;
    logic                    occ;

    always_comb
    begin
        occ         = (IDX < int'(count));
        gt          = occ && (key_reg > ctrl.key);
        key_next    = key_reg;
        weight_next = weight_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (left_gt)
                begin
                    key_next    = left_key;
                    weight_next = left_weight;
                end
                else if (gt || !occ)
                begin
                    key_next    = ctrl.key;
                    weight_next = ctrl.weight;
                end
            end
            CELL_REMOVE:
            begin
                if (IDX >= int'(ctrl.pos))
                begin
                    key_next    = right_key;
                    weight_next = right_weight;
                end
            end
            default:
            begin
                key_next    = key_reg;
                weight_next = weight_reg;
            end
        endcase
        // expose the pre-shift key of the selected cell
        tap_next = (ctrl.op == CELL_REMOVE && IDX == int'(ctrl.pos)) ? key_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        weight_reg <= weight_next;
        if (tap_load)
        begin
            tap_reg <= tap_next;
        end
    end

    assign key    = key_reg;
    assign weight = weight_reg;
    assign tap    = tap_reg;

endmodule

### rtl/core/sil_tap_reduce.sv
// Two-level OR tree that collects the removed key from the cell taps.
// Depends on sil_pkg.
module sil_tap_reduce (
    input  logic                      clk,
    input  logic                      load,
    input  logic [sil_pkg::KEY_W-1:0] taps [sil_pkg::TAP_N],
    output logic [sil_pkg::KEY_W-1:0] result
);
    import sil_pkg::*;

    logic [KEY_W-1:0] group_reg  [TAP_GROUPS];
    logic [KEY_W-1:0] group_next [TAP_GROUPS];

    always_comb
    begin
        for (int g = 0; g < TAP_GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int t = 0; t < TAP_GROUP; t++)
            begin
                group_next[g] = group_next[g] | taps[g * TAP_GROUP + t];
            end
        end
        result = '0;
        for (int g = 0; g < TAP_GROUPS; g++)
        begin
            result = result | group_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < TAP_GROUPS; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
    end

endmodule

### rtl/core/sorted_insert_list.sv
// Sorted insert list: top level. Builds the cell chain, sequencer and output register.
// Depends on sil_pkg, sil_cell and sil_tap_reduce.

// The list holds up to CAPACITY entries (key and weight) in ascending key
// order inside a chain of cells; an insert lands before the first entry
// with a strictly greater key, so equal keys keep arrival order. Each
// transfer in yields one result transfer out with status, removed key,
// entry count and empty flag. The result is offered once its input transfer
// has passed the shift state, where all cells compare and shift in parallel,
// the reduce state, which loads the registered first level of the OR tree
// gathering the removed key from the cell taps, and the final state, which
// loads the output register once that is free. The input is ready again in
// the cycle after the result is loaded into the output register; no new item
// is taken before that. Reset empties the list at once; no clearing pass.
module sorted_insert_list #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] key, [63:32] weight, [69:64] position, [71:70] zero
    input  logic [71:0] s_axis_tdata,
    // [0] req_type
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [33:2] removed_key, [40:34] entry_count, [41] is_empty, [47:42] zero
    output logic [47:0] m_axis_tdata
);
    import sil_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RED  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // latched request
    logic                    req_type_reg;
    logic signed [KEY_W-1:0] req_key_reg;
    logic signed [KEY_W-1:0] req_weight_reg;
    logic [POS_W-1:0]        req_pos_reg;

    logic [1:0]       status_reg, status_next;
    logic [1:0]       exec_op;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic [OUT_CNT_W-1:0] out_count_reg;
    logic             out_empty_reg;

    logic             in_xfer;
    logic             out_load;
    cell_ctrl_t       ctrl;

    logic signed [KEY_W-1:0] cell_key    [CAPACITY];
    logic signed [KEY_W-1:0] cell_weight [CAPACITY];
    logic                    cell_gt     [CAPACITY];
    logic [KEY_W-1:0]        cell_tap    [CAPACITY];
    logic [KEY_W-1:0]        taps        [TAP_N];
    logic [KEY_W-1:0]        removed_key;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_FIN) && (!out_valid_reg || m_axis_tready);

    // decide the operation and its status from the current count
    always_comb
    begin
        exec_op     = CELL_HOLD;
        status_next = STATUS_OK;
        count_next  = count_reg;
        if (req_type_reg == REQ_INSERT)
        begin
            if (count_reg < CNT_W'(CAPACITY))
            begin
                exec_op    = CELL_INSERT;
                count_next = count_reg + 1'b1;
            end
            else
            begin
                status_next = STATUS_FULL;
            end
        end
        else
        begin
            if (int'(req_pos_reg) < int'(count_reg))
            begin
                exec_op    = CELL_REMOVE;
                count_next = count_reg - 1'b1;
            end
            else
            begin
                status_next = STATUS_BAD;
            end
        end
    end

    always_comb
    begin
        ctrl.op     = (state_reg == ST_EXEC) ? exec_op : CELL_HOLD;
        ctrl.key    = req_key_reg;
        ctrl.weight = req_weight_reg;
        ctrl.pos    = req_pos_reg;
    end

    // sequencer: latch, shift the chain, reduce taps, hand off the result
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_xfer) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_RED;
            ST_RED:  state_next = ST_FIN;
            ST_FIN:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_EXEC)
            begin
                count_reg <= count_next;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_type_reg   <= s_axis_tuser[0];
            req_key_reg    <= s_axis_tdata[31:0];
            req_weight_reg <= s_axis_tdata[63:32];
            req_pos_reg    <= s_axis_tdata[69:64];
        end
        if (state_reg == ST_EXEC)
        begin
            status_reg <= status_next;
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_key_reg    <= removed_key;
            out_count_reg  <= OUT_CNT_W'(count_reg);
            out_empty_reg  <= (count_reg == '0);
        end
    end

    // chain of cells; the ends see a neighbor that never claims a greater key
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                    l_gt;
        logic signed [KEY_W-1:0] l_key, l_weight, r_key, r_weight;

        if (i == 0)
        begin : g_first
            assign l_gt     = 1'b0;
            assign l_key    = '0;
            assign l_weight = '0;
        end
        else
        begin : g_mid_l
            assign l_gt     = cell_gt[i-1];
            assign l_key    = cell_key[i-1];
            assign l_weight = cell_weight[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_key    = '0;
            assign r_weight = '0;
        end
        else
        begin : g_mid_r
            assign r_key    = cell_key[i+1];
            assign r_weight = cell_weight[i+1];
        end

        sil_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .count        (count_reg),
            .tap_load     (state_reg == ST_EXEC),
            .left_gt      (l_gt),
            .left_key     (l_key),
            .left_weight  (l_weight),
            .right_key    (r_key),
            .right_weight (r_weight),
            .key          (cell_key[i]),
            .weight       (cell_weight[i]),
            .gt           (cell_gt[i]),
            .tap          (cell_tap[i])
        );
    end

    // only the first TAP_N cells can be addressed by a position
    for (genvar j = 0; j < TAP_N; j++)
    begin : g_tap
        if (j < CAPACITY)
        begin : g_used
            assign taps[j] = cell_tap[j];
        end
        else
        begin : g_unused
            assign taps[j] = '0;
        end
    end

    sil_tap_reduce u_reduce (
        .clk    (clk),
        .load   (state_reg == ST_RED),
        .taps   (taps),
        .result (removed_key)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_empty_reg, out_count_reg, out_key_reg, out_status_reg};

    // an accepted transfer always starts the shift cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_EXEC))
        else $error("accepted request did not enter the shift cycle");

    // the count never exceeds the capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(CAPACITY)))
        else $error("entry count beyond capacity");

    // a refused operation leaves the count unchanged
    a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EXEC) && (status_next != STATUS_OK)) |=> $stable(count_reg))
        else $error("refused operation changed the count");

    // a refused result carries a zero removed key
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != STATUS_OK)) |-> (out_key_reg == '0))
        else $error("refused result carries a nonzero key");

endmodule

### verif/sorted_list_checker.sv
// Checker for the sorted insert list: watches both stream channels, predicts every
// result from a private copy of the list and compares it field by field.
// Depends on sil_pkg for field widths, request codes and status codes.
module sorted_list_checker #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    import sil_pkg::*;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] removed_key;
        logic [OUT_CNT_W-1:0]    entry_count;
        logic                    is_empty;
    } list_result_t;

    logic signed [KEY_W-1:0] held_keys    [CAPACITY];
    logic signed [KEY_W-1:0] held_weights [CAPACITY];
    int                      held_count;
    list_result_t            expected_results [$];

    // Apply one operation to the private list; return what the block should report.
    function automatic list_result_t apply_list_op(
        input logic                    req,
        input logic signed [KEY_W-1:0] key,
        input logic signed [KEY_W-1:0] weight,
        input logic [POS_W-1:0]        pos
    );
        list_result_t res;
        int           slot;
        int           i;
        res = '0;
        res.status = STATUS_OK;
        if (req == REQ_INSERT)
        begin
            if (held_count >= CAPACITY)
                res.status = STATUS_FULL;
            else
            begin
                // first entry with a strictly greater key; equal keys stay ahead
                slot = held_count;
                for (i = held_count - 1; i >= 0; i--)
                    if (held_keys[i] > key)
                        slot = i;
                for (i = held_count; i > slot; i--)
                begin
                    held_keys[i]    = held_keys[i - 1];
                    held_weights[i] = held_weights[i - 1];
                end
                held_keys[slot]    = key;
                held_weights[slot] = weight;
                held_count++;
            end
        end
        else
        begin
            if (pos >= held_count)
                res.status = STATUS_BAD;
            else
            begin
                res.removed_key = held_keys[pos];
                for (i = pos; i < held_count - 1; i++)
                begin
                    held_keys[i]    = held_keys[i + 1];
                    held_weights[i] = held_weights[i + 1];
                end
                held_count--;
            end
        end
        res.entry_count = OUT_CNT_W'(held_count);
        res.is_empty    = (held_count == 0);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] want_v,
                                   input logic [47:0] got_v);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch in %s at %0t: expected %0h, got %0h", what, $time, want_v, got_v);
    endtask

    task automatic check_result(input logic [47:0] beat);
        list_result_t got;
        list_result_t want;
        got.status      = beat[1:0];
        got.removed_key = beat[33:2];
        got.entry_count = beat[40:34];
        got.is_empty    = beat[41];
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with no request outstanding", '0, beat);
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", 48'(want.status), 48'(got.status));
        if (got.removed_key !== want.removed_key)
            report_mismatch("removed_key", 48'($unsigned(want.removed_key)),
                            48'($unsigned(got.removed_key)));
        if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", 48'(want.entry_count), 48'(got.entry_count));
        if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", 48'(want.is_empty), 48'(got.is_empty));
    endtask

    // A result can never stem from a request taken at the same edge, so check first.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            expected_results.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_list_op(s_tuser[0], s_tdata[31:0],
                                                         s_tdata[63:32], s_tdata[69:64]));
            pending = expected_results.size();
        end
    end

endmodule

### verif/testbench.sv
// Top of the sorted insert list testbench: clock, reset, stimulus and verdict.
// Depends on sil_pkg, sorted_insert_list and sorted_list_checker.
module testbench;
    import sil_pkg::*;

    localparam int CAPACITY     = 64;
    // long receiver hold-off, so the block backs up and stalls its input
    localparam int HOLD_CYCLES  = 300;
    // the block offers a result after its shift, reduce and output-load states
    localparam int DRAIN_CYCLES = 8;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [31:0] key, [63:32] weight, [69:64] position, [71:70] zero
    logic [71:0] s_axis_tdata;
    // [0] req_type
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [1:0] status, [33:2] removed_key, [40:34] entry_count, [41] is_empty
    logic [47:0] m_axis_tdata;

    int          fail_count;
    int          pending;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          phase;
    logic        rx_hold = 1'b0;
    event        start_rx_hold;

    sorted_insert_list #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    sorted_list_checker #(
        .CAPACITY(CAPACITY)
    ) list_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    // Receiver: drop tready at random, or hold it low through a hold-off stretch.
    always @(negedge clk)
        m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);

    // Count out the hold-off on rising edges, so the receiver reads a settled flag.
    always
    begin
        @(start_rx_hold);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // Offer one request from a falling edge and hold it until the transfer happens.
    // Random idle cycles go in ahead of the request.
    task automatic send_op(
        input logic                    req,
        input logic signed [KEY_W-1:0] key,
        input logic signed [KEY_W-1:0] weight,
        input logic [POS_W-1:0]        pos
    );
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {2'b00, pos, weight, key};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random request. Many keys come from a narrow band so that equal keys pile up,
    // some are extremes, the rest span the whole range. Positions lean low so removes
    // mostly hit stored entries, while the full six-bit reach still shows up.
    task automatic send_random_op(input int insert_pct);
        logic                    req;
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        pos;
        int                      pick;
        req  = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            key = $urandom_range(0, 15) - 8;
        else if (pick == 4)
        begin
            case ($urandom_range(0, 3))
                0:       key = 32'sh7FFFFFFF;
                1:       key = 32'sh80000000;
                2:       key = '0;
                default: key = '1;
            endcase
        end
        else
            key = $urandom;
        if ($urandom_range(0, 9) < 6)
            pos = POS_W'($urandom_range(0, 7));
        else
            pos = POS_W'($urandom_range(0, 63));
        send_op(req, key, $urandom, pos);
    endtask

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: removes on an empty list, both key and weight extremes, equal keys
        // keeping arrival order, unused fields set to all ones, removes of the first and
        // the last entry, and positions at and past the count.
        send_op(REQ_REMOVE, '0, '0, 6'd0);
        send_op(REQ_REMOVE, '0, '0, 6'd63);
        send_op(REQ_INSERT, '0, '0, 6'd0);
        send_op(REQ_INSERT, 32'sh7FFFFFFF, 32'sh80000000, 6'd0);
        send_op(REQ_INSERT, 32'sh80000000, 32'sh7FFFFFFF, 6'd0);
        send_op(REQ_INSERT, '0, 32'sd1, 6'd0);
        send_op(REQ_INSERT, '0, '1, 6'd63);
        send_op(REQ_INSERT, '1, '1, 6'd0);
        send_op(REQ_INSERT, 32'sd1, 32'sd7, 6'd0);
        // list now: min, -1, 0, 0, 0, 1, max
        send_op(REQ_REMOVE, '1, '1, 6'd1);
        send_op(REQ_REMOVE, '0, '0, 6'd5);
        send_op(REQ_REMOVE, '0, '0, 6'd5);
        send_op(REQ_REMOVE, '0, '0, 6'd63);
        send_op(REQ_REMOVE, '0, '0, 6'd0);
        send_op(REQ_REMOVE, '0, '0, 6'd3);
        send_op(REQ_REMOVE, '0, '0, 6'd0);
        send_op(REQ_REMOVE, '0, '0, 6'd0);
        send_op(REQ_REMOVE, '0, '0, 6'd0);
        send_op(REQ_REMOVE, '0, '0, 6'd0);

        // Random: in each idling setting fill the list past full, drain it past empty,
        // then mix. The second setting opens with a long receiver hold-off.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 9;
                    rx_idle_pct = 48;
                end
                1:
                begin
                    tx_idle_pct = 48;
                    rx_idle_pct = 9;
                    -> start_rx_hold;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            repeat (110) send_random_op(85);
            repeat (110) send_random_op(20);
            repeat (95) send_random_op(50);
            // pause the sender until every outstanding result has come back
            s_axis_tvalid <= 1'b0;
            do
                @(negedge clk);
            while (pending != 0);
        end

        // let any stray result surface before the verdict
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
